[hdl/spi3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spi3_pkg;

	localparam int WORD_BITS = 8;
	localparam int BIT_CNT_W = $clog2(WORD_BITS);
	localparam int TICK_W    = 8;

	localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 8'd4;

	// command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// direction codes; the fourth code behaves as full duplex
	localparam logic [1:0] DIR_TX   = 2'd0;
	localparam logic [1:0] DIR_RX   = 2'd1;
	localparam logic [1:0] DIR_FULL = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOW,
		ST_HIGH
	} eng_state_t;

	// classified item, front to back
	typedef struct packed {
		logic                 is_load;
		logic [WORD_BITS-1:0] tx_byte;
		logic                 sends;
		logic                 receives;
		logic                 last;
		logic                 miso;
	} op_t;

	// one result beat
	typedef struct packed {
		logic                 sclk;
		logic                 mosi;
		logic                 cs_n;
		logic [WORD_BITS-1:0] rx_byte;
		logic                 rx_done;
		logic                 busy;
		logic                 refused;
	} result_t;

endpackage

`default_nettype wire

[hdl/spi3_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module spi3_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= bump(wr_ptr_q);
			if (rd_en)
				rd_ptr_q <= bump(rd_ptr_q);
			cnt_q <= cnt_q + CNT_W'(wr_en) - CNT_W'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);

endmodule

`default_nettype wire

[hdl/spi3_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module spi3_front
	import spi3_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic                 command,
	input  wire logic [WORD_BITS-1:0] tx_byte,
	input  wire logic [1:0]           direction,
	input  wire logic                 last_byte,
	input  wire logic                 miso_level,
	output op_t                       op,
	output logic                      op_valid,
	input  wire logic                 op_take
);

	op_t                 op_in;
	logic                wr_en;
	logic                op_empty;
	logic [$bits(op_t)-1:0] op_bits;

	// decode direction into send / receive flags
	always_comb begin
		op_in.is_load  = (command == CMD_LOAD);
		op_in.tx_byte  = tx_byte;
		op_in.sends    = (direction != DIR_RX);
		op_in.receives = (direction != DIR_TX);
		op_in.last     = last_byte;
		op_in.miso     = miso_level;
	end

	assign wr_en = push && !full;

	spi3_fifo #(
		.WIDTH ($bits(op_t)),
		.DEPTH (DEPTH)
	) u_op_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (op_in),
		.full    (full),
		.rd_en   (op_take),
		.rd_data (op_bits),
		.empty   (op_empty)
	);

	assign op       = op_t'(op_bits);
	assign op_valid = !op_empty;

endmodule

`default_nettype wire

[hdl/spi3_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module spi3_engine
	import spi3_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [TICK_W-1:0] half_period,
	input  wire op_t               op,
	input  wire logic              op_valid,
	output logic                   op_take,
	output result_t                res,
	output logic                   empty,
	input  wire logic              pop
);

	eng_state_t state_q, state_d;

	logic [WORD_BITS-1:0] tx_shift_q, tx_shift_d;
	logic [WORD_BITS-1:0] rx_shift_q, rx_shift_d;
	logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
	logic [TICK_W-1:0]    tick_q, tick_d;
	logic                 sends_q, sends_d;
	logic                 recv_q, recv_d;
	logic                 release_q, release_d;
	logic                 clock_q, clock_d;
	logic                 data_q, data_d;
	logic                 select_q, select_d;

	logic [TICK_W-1:0]    tick_next;
	logic                 tick_wrap;
	logic                 last_bit;
	logic                 is_tick;
	logic                 res_full;
	result_t              res_d;
	logic [WORD_BITS-1:0] rx_new;
	logic [$bits(result_t)-1:0] res_bits;

	// take an item when the result queue has room, or frees one this cycle
	assign op_take   = op_valid && (!res_full || pop);
	assign is_tick   = op_take && !op.is_load;
	assign tick_next = tick_q + TICK_W'(1);
	assign tick_wrap = (tick_next == half_period);
	assign last_bit  = (bit_cnt_q == BIT_CNT_W'(WORD_BITS - 1));
	assign rx_new    = recv_q ? {rx_shift_q[WORD_BITS-2:0], op.miso} : rx_shift_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (op_take && op.is_load)
					state_d = ST_LOW;
			end
			ST_LOW: begin
				if (is_tick && tick_wrap)
					state_d = ST_HIGH;
			end
			ST_HIGH: begin
				if (is_tick && tick_wrap)
					state_d = last_bit ? ST_IDLE : ST_LOW;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		tx_shift_d = tx_shift_q;
		rx_shift_d = rx_shift_q;
		bit_cnt_d  = bit_cnt_q;
		tick_d     = tick_q;
		sends_d    = sends_q;
		recv_d     = recv_q;
		release_d  = release_q;
		clock_d    = clock_q;
		data_d     = data_q;
		select_d   = select_q;
		res_d      = '0;

		if (op_take && op.is_load) begin
			if (state_q != ST_IDLE) begin
				res_d.refused = 1'b1;
			end else begin
				// open the byte and drive its first bit
				rx_shift_d = '0;
				bit_cnt_d  = '0;
				tick_d     = '0;
				sends_d    = op.sends;
				recv_d     = op.receives;
				release_d  = op.last;
				select_d   = 1'b0;
				clock_d    = 1'b0;
				if (op.sends)
					data_d = op.tx_byte[WORD_BITS-1];
				tx_shift_d = {op.tx_byte[WORD_BITS-2:0], 1'b0};
			end
		end else if (is_tick && state_q != ST_IDLE) begin
			if (!tick_wrap) begin
				tick_d = tick_next;
			end else if (state_q == ST_LOW) begin
				clock_d = 1'b1;
				tick_d  = '0;
			end else begin
				// sample side of the bit
				rx_shift_d = rx_new;
				tick_d     = '0;
				if (last_bit) begin
					bit_cnt_d     = '0;
					res_d.rx_done = recv_q;
					if (recv_q)
						res_d.rx_byte = rx_new;
					if (release_q)
						select_d = 1'b1;
				end else begin
					bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
					clock_d   = 1'b0;
					if (sends_q)
						data_d = tx_shift_q[WORD_BITS-1];
					tx_shift_d = {tx_shift_q[WORD_BITS-2:0], 1'b0};
				end
			end
		end

		res_d.sclk = clock_d;
		res_d.mosi = data_d;
		res_d.cs_n = select_d;
		res_d.busy = (state_d != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tx_shift_q <= '0;
			rx_shift_q <= '0;
			bit_cnt_q  <= '0;
			tick_q     <= '0;
			sends_q    <= 1'b1;
			recv_q     <= 1'b0;
			release_q  <= 1'b0;
			clock_q    <= 1'b1;
			data_q     <= 1'b1;
			select_q   <= 1'b1;
		end else if (op_take) begin
			state_q    <= state_d;
			tx_shift_q <= tx_shift_d;
			rx_shift_q <= rx_shift_d;
			bit_cnt_q  <= bit_cnt_d;
			tick_q     <= tick_d;
			sends_q    <= sends_d;
			recv_q     <= recv_d;
			release_q  <= release_d;
			clock_q    <= clock_d;
			data_q     <= data_d;
			select_q   <= select_d;
		end
	end

	spi3_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (op_take),
		.wr_data (res_d),
		.full    (res_full),
		.rd_en   (pop && !empty),
		.rd_data (res_bits),
		.empty   (empty)
	);

	assign res = result_t'(res_bits);

	a_clock_tracks_phase: assert property (@(posedge clk) disable iff (!arst_n)
		clock_q == (state_q != ST_LOW))
		else $error("serial clock level disagrees with bit phase");

	a_idle_counters_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (tick_q == '0 && bit_cnt_q == '0))
		else $error("divider or bit counter left dirty after byte");

	a_refuse_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(op_take && res_d.refused) |-> (state_q != ST_IDLE && res_d.busy))
		else $error("load refused while engine idle");

	a_done_ends_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(op_take && res_d.rx_done) |=> (state_q == ST_IDLE && clock_q))
		else $error("receive completion without end of byte");

endmodule

`default_nettype wire

[hdl/spi_master_mode3_shifter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// SPI master, mode 3 (clock idles high), MSB first, 8-bit words. Each input
// beat is either a tick (one unit of the bit-rate divider passes) or a load
// that starts one byte as transmit, receive or full duplex; chip select drops
// on the first load of a frame and rises after a byte flagged last_byte. Every
// accepted beat yields exactly one result beat carrying the line levels after
// that beat, the received byte when a receiving byte finishes, busy_res and
// load_refused (a load that hits a busy shifter). The block takes one beat
// per clock: the shifter steps once per cycle, so the sustained rate is one
// item per cycle as long as results are popped. A pushed beat is first
// registered in the command queue, and its result is then registered in
// the result queue. full rises only when IN_DEPTH beats are waiting;
// the shifter halts when OUT_DEPTH results sit unpopped. half_period is set
// through the cfg channel (always ready, reset value 4) and must be written
// only while no beats are in flight; a value of 0 gives 256-tick phases.
module spi_master_mode3_shifter_unit
	import spi3_pkg::*;
#(
	parameter int IN_DEPTH  = 4,
	parameter int OUT_DEPTH = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// command side
	input  wire logic                 push,
	output logic                      full,
	input  wire logic                 command,
	input  wire logic [WORD_BITS-1:0] tx_byte,
	input  wire logic [1:0]           direction,
	input  wire logic                 last_byte,
	input  wire logic                 miso_level,
	// configuration
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [TICK_W-1:0]    cfg_data,
	// result side
	output logic                      empty,
	input  wire logic                 pop,
	output logic                      sclk,
	output logic                      mosi,
	output logic                      cs_n,
	output logic [WORD_BITS-1:0]      rx_byte,
	output logic                      rx_done,
	output logic                      busy_res,
	output logic                      load_refused
);

	logic [TICK_W-1:0] half_period_q;
	op_t               op;
	logic              op_valid;
	logic              op_take;
	result_t           res;

	// the divider setting is a plain register, written any time a beat lands
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			half_period_q <= cfg_data;
		end
	end

	// front: decode and queue command beats
	spi3_front #(
		.DEPTH (IN_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.tx_byte    (tx_byte),
		.direction  (direction),
		.last_byte  (last_byte),
		.miso_level (miso_level),
		.op         (op),
		.op_valid   (op_valid),
		.op_take    (op_take)
	);

	// back: bit engine plus result queue
	spi3_engine #(
		.DEPTH (OUT_DEPTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.half_period (half_period_q),
		.op          (op),
		.op_valid    (op_valid),
		.op_take     (op_take),
		.res         (res),
		.empty       (empty),
		.pop         (pop)
	);

	assign sclk         = res.sclk;
	assign mosi         = res.mosi;
	assign cs_n         = res.cs_n;
	assign rx_byte      = res.rx_byte;
	assign rx_done      = res.rx_done;
	assign busy_res     = res.busy;
	assign load_refused = res.refused;

endmodule

`default_nettype wire
